// ----- rtl/cnbm_pkg.sv -----
// Shared constants for the cluster NMS box merge block.
`default_nettype none
package cnbm_pkg;
	localparam int DEF_MAX_DETECTIONS = 64;
	localparam int DEF_COORD_BITS     = 12;
	localparam int DEF_SCORE_BITS     = 16;

	localparam int THR_W      = 17;
	localparam int THR_FRAC   = 16;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [THR_W-1:0] THR_ONE   = 17'h10000;
	localparam logic [THR_W-1:0] THR_RESET = 17'h08000;

	localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WMEAN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILT = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/cnbm_if.sv -----
// Stream interfaces for detections in and merged boxes out.
`default_nettype none
interface cnbm_det_if
	import cnbm_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int SCORE_BITS = DEF_SCORE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] box_x;
	logic [COORD_BITS-1:0] box_y;
	logic [COORD_BITS-1:0] box_w;
	logic [COORD_BITS-1:0] box_h;
	logic [SCORE_BITS-1:0] score;
	logic                  last;

	modport source (output valid, box_x, box_y, box_w, box_h, score, last, input ready);
	modport sink (input valid, box_x, box_y, box_w, box_h, score, last, output ready);
endinterface

interface cnbm_res_if
	import cnbm_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int SCORE_BITS = DEF_SCORE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] out_x;
	logic [COORD_BITS-1:0] out_y;
	logic [COORD_BITS-1:0] out_w;
	logic [COORD_BITS-1:0] out_h;
	logic [SCORE_BITS-1:0] out_score;
	logic                  out_last;
	logic                  no_survivors;
	logic                  overflowed;

	modport source (output valid, out_x, out_y, out_w, out_h, out_score, out_last,
		no_survivors, overflowed, input ready);
	modport sink (input valid, out_x, out_y, out_w, out_h, out_score, out_last,
		no_survivors, overflowed, output ready);
endinterface
`default_nettype wire

// ----- rtl/cnbm_ram.sv -----
// Generic single write port RAM with registered read.
`default_nettype none
module cnbm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/cnbm_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module cnbm_div #(
	parameter int NUM_W = 36,
	parameter int DEN_W = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output      logic             busy,
	output      logic             done,
	output      logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   sh;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign sh   = {rem_q, q_q[NUM_W-1]};
	assign ge   = sh >= {1'b0, den_q};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			q_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				den_q  <= den;
				q_q    <= num;
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
				q_q   <= {q_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = q_q;
endmodule
`default_nettype wire

// ----- rtl/cnbm_isect.sv -----
// Intersection of two boxes packed as {x, y, w, h}; empty gives all zero.
`default_nettype none
module cnbm_isect #(
	parameter int COORD_BITS = 12
) (
	input  wire logic [4*COORD_BITS-1:0] a,
	input  wire logic [4*COORD_BITS-1:0] b,
	output      logic [4*COORD_BITS-1:0] o
);
	localparam int CW = COORD_BITS;

	logic [CW-1:0] ax, ay, aw, ah, bx, by, bw, bh, x1, y1;
	logic [CW:0]   ax2, ay2, bx2, by2, x2, y2, dw, dh;

	always_comb begin
		{ax, ay, aw, ah} = a;
		{bx, by, bw, bh} = b;
		ax2 = {1'b0, ax} + {1'b0, aw};
		ay2 = {1'b0, ay} + {1'b0, ah};
		bx2 = {1'b0, bx} + {1'b0, bw};
		by2 = {1'b0, by} + {1'b0, bh};
		x1  = (ax > bx) ? ax : bx;
		y1  = (ay > by) ? ay : by;
		x2  = (ax2 < bx2) ? ax2 : bx2;
		y2  = (ay2 < by2) ? ay2 : by2;
		dw  = x2 - {1'b0, x1};
		dh  = y2 - {1'b0, y1};
		if (x2 > {1'b0, x1} && y2 > {1'b0, y1}) begin
			o = {x1, y1, dw[CW-1:0], dh[CW-1:0]};
		end else begin
			o = '0;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/cluster_nms_box_merge.sv -----
// Cluster NMS box merge: greedy clustering suppression with box averaging.
// Detections are taken one per cycle while the block is loading, and up to
// MAX_DETECTIONS are stored in a detection RAM, later ones only flagging an
// overflow; each entry carries its taken flag, which a load clears and a
// gather sets by writing the entry back. After the transfer marked last, each
// cluster costs one leader scan, leader setup, a gather scan, a merge step that
// keeps the leader box or, when averaging, four divisions in turn through one
// shared divider, and one write-back; a final leader scan that finds no leader
// ends the pass. A threshold of one or more instead copies the set. The
// containment filter, when enabled, then compares result boxes read from the
// result RAM, and each surviving box is emitted in turn, held through any
// output stall, while each dropped box is skipped. No new detection is taken
// until the last result of a set has been transferred.
`default_nettype none
module cluster_nms_box_merge
	import cnbm_pkg::*;
#(
	parameter int MAX_DETECTIONS = DEF_MAX_DETECTIONS,
	parameter int COORD_BITS     = DEF_COORD_BITS,
	parameter int SCORE_BITS     = DEF_SCORE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	cnbm_det_if.sink                   det,
	cnbm_res_if.source                 res,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
	localparam int N      = MAX_DETECTIONS;
	localparam int CW     = COORD_BITS;
	localparam int SW     = SCORE_BITS;
	localparam int IW     = $clog2(N);
	localparam int CNT_W  = $clog2(N + 1);
	localparam int BOX_W  = 4*CW + SW;
	localparam int ENT_W  = BOX_W + 1;
	localparam int AREA_W = 2*CW;
	localparam int TLA_W  = THR_W + AREA_W;
	localparam int SUM_W  = CW + CNT_W;
	localparam int WP_W   = SW + CW;
	localparam int WSUM_W = SW + CW + CNT_W;
	localparam int WS_W   = SW + CNT_W;
	localparam int NUM_W  = WSUM_W + 1;
	localparam int DEN_W  = WS_W + 1;

	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_COPY   = 4'd1;
	localparam logic [3:0] S_LSCAN  = 4'd2;
	localparam logic [3:0] S_AREA   = 4'd3;
	localparam logic [3:0] S_TLA    = 4'd4;
	localparam logic [3:0] S_GATHER = 4'd5;
	localparam logic [3:0] S_DSEL   = 4'd6;
	localparam logic [3:0] S_DWAIT  = 4'd7;
	localparam logic [3:0] S_WRES   = 4'd8;
	localparam logic [3:0] S_FRD    = 4'd9;
	localparam logic [3:0] S_FLAT   = 4'd10;
	localparam logic [3:0] S_FSCAN  = 4'd11;
	localparam logic [3:0] S_ERD    = 4'd12;
	localparam logic [3:0] S_ELAT   = 4'd13;
	localparam logic [3:0] S_EWAIT  = 4'd14;

	logic [3:0]        state_q;
	logic [THR_W-1:0]  thr_q;
	logic [MODE_W-1:0] mode_q;
	logic              filt_q;
	logic [CNT_W-1:0]  load_q, nr_q, addr_q, i_q, total_q, k_q, cnt_q;
	logic              ovf_q, found_q, drop_q, la_zero_q;
	logic [IW-1:0]     idx_s1, idx_s2, idx_s3;
	logic              v_s1, v_s2, v_s3, tk_s2, tk_s3;
	logic [1:0]        dsel_q;

	logic [4*CW-1:0]   lead_box_q, ri_q, gi_s2, box_s2, box_s3;
	logic [SW-1:0]     lead_s_q, s_s2, s_s3, ris_q;
	logic [AREA_W-1:0] la_q, ia_s3;
	logic [TLA_W-1:0]  tla_q;
	logic [CW-1:0]     rc_q [4];
	logic [SUM_W-1:0]  sum_q [4];
	logic [WSUM_W-1:0] wsum_q [4];
	logic [WP_W-1:0]   wp_s3 [4];
	logic [WS_W-1:0]   ws_q;

	logic              ovalid_q, olast_q, onos_q, oovf_q;
	logic [CW-1:0]     ox_q, oy_q, ow_q, oh_q;
	logic [SW-1:0]     os_q;

	logic [ENT_W-1:0]  det_rdata, det_wdata, res_rdata, res_wdata;
	logic              res_we, det_ram_we;
	logic [IW-1:0]     res_waddr, res_raddr, det_waddr;
	logic              det_fire, det_we, issue, take, gather_done;
	logic              lead_better, contained, use_mean, use_wmean, dstart;
	logic              dbusy, ddone;
	logic [NUM_W-1:0]  dnum, dquo;
	logic [DEN_W-1:0]  dden;
	logic [CNT_W-1:0]  lim;
	logic [4*CW-1:0]   d_box, r_box, gi, fi;
	logic [SW-1:0]     d_s;
	logic [TLA_W-1:0]  ia_sh;

	assign det.ready = (state_q == S_LOAD);
	assign det_fire  = det.valid && det.ready;
	assign det_we    = det_fire && (load_q < CNT_W'(N));

	assign d_box = det_rdata[ENT_W-1:SW+1];
	assign d_s   = det_rdata[SW:1];
	assign r_box = res_rdata[ENT_W-1:SW+1];

	assign lim   = (state_q == S_FSCAN) ? nr_q : load_q;
	assign issue = ((state_q == S_COPY) || (state_q == S_LSCAN) || (state_q == S_GATHER) ||
		(state_q == S_FSCAN)) && (addr_q < lim);

	assign ia_sh = TLA_W'({ia_s3, {THR_FRAC{1'b0}}});
	assign take  = v_s3 && !tk_s3 && (la_zero_q || (ia_sh > tla_q));
	assign gather_done = (state_q == S_GATHER) && (addr_q == load_q) && !v_s1 && !v_s2 &&
		!v_s3;
	assign lead_better = v_s1 && !det_rdata[0] && (!found_q || (d_s >= lead_s_q));
	assign contained   = v_s1 && (idx_s1 != i_q[IW-1:0]) && (fi == ri_q);

	assign use_mean  = (mode_q == MODE_MEAN) && (cnt_q != '0);
	assign use_wmean = (mode_q == MODE_WMEAN) && (ws_q != '0);
	assign dstart    = (state_q == S_DSEL) && (use_mean || use_wmean);

	// taken flag rides in bit 0 of each detection entry
	assign det_ram_we = det_we || take;
	assign det_waddr  = take ? idx_s3 : load_q[IW-1:0];
	assign det_wdata  = take ? {box_s3, s_s3, 1'b1} :
		{det.box_x, det.box_y, det.box_w, det.box_h, det.score, 1'b0};

	always_comb begin
		if (use_wmean) begin
			dnum = NUM_W'({wsum_q[dsel_q], 1'b0}) + NUM_W'(ws_q);
			dden = {ws_q, 1'b0};
		end else begin
			dnum = NUM_W'({sum_q[dsel_q], 1'b0}) + NUM_W'(cnt_q);
			dden = DEN_W'({cnt_q, 1'b0});
		end
	end

	// keep flag rides in bit 0 of each result entry
	always_comb begin
		if (state_q == S_COPY) begin
			res_we    = v_s1;
			res_waddr = idx_s1;
			res_wdata = {det_rdata[ENT_W-1:1], 1'b1};
		end else if (state_q == S_FSCAN) begin
			res_we    = (addr_q == nr_q) && !v_s1;
			res_waddr = i_q[IW-1:0];
			res_wdata = {ri_q, ris_q, !drop_q};
		end else begin
			res_we    = (state_q == S_WRES);
			res_waddr = nr_q[IW-1:0];
			res_wdata = {rc_q[0], rc_q[1], rc_q[2], rc_q[3], lead_s_q, 1'b1};
		end
		res_raddr = (state_q == S_FSCAN) ? addr_q[IW-1:0] : i_q[IW-1:0];
	end

	cnbm_ram #(.WIDTH(ENT_W), .DEPTH(N)) u_det_ram (
		.clk   (clk),
		.we    (det_ram_we),
		.waddr (det_waddr),
		.wdata (det_wdata),
		.raddr (addr_q[IW-1:0]),
		.rdata (det_rdata)
	);

	cnbm_ram #(.WIDTH(ENT_W), .DEPTH(N)) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (res_waddr),
		.wdata (res_wdata),
		.raddr (res_raddr),
		.rdata (res_rdata)
	);

	cnbm_isect #(.COORD_BITS(CW)) u_gather_isect (
		.a (lead_box_q),
		.b (d_box),
		.o (gi)
	);

	cnbm_isect #(.COORD_BITS(CW)) u_filt_isect (
		.a (ri_q),
		.b (r_box),
		.o (fi)
	);

	cnbm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.num    (dnum),
		.den    (dden),
		.busy   (dbusy),
		.done   (ddone),
		.quo    (dquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			thr_q      <= THR_RESET;
			mode_q     <= MODE_MEAN;
			filt_q     <= 1'b1;
			load_q     <= '0;
			nr_q       <= '0;
			addr_q     <= '0;
			i_q        <= '0;
			total_q    <= '0;
			k_q        <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			found_q    <= 1'b0;
			drop_q     <= 1'b0;
			idx_s1     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			dsel_q     <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_THR:  thr_q  <= cfg_wdata[THR_W-1:0];
					REG_MODE: mode_q <= cfg_wdata[MODE_W-1:0];
					REG_FILT: filt_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			v_s1   <= issue;
			idx_s1 <= addr_q[IW-1:0];
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			v_s2 <= v_s1 && (state_q == S_GATHER);
			v_s3 <= v_s2;

			case (state_q)
				S_LOAD: begin
					if (det_fire) begin
						if (det_we) begin
							load_q <= load_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (det.last) begin
							addr_q  <= '0;
							found_q <= 1'b0;
							nr_q    <= '0;
							state_q <= (thr_q >= THR_ONE) ? S_COPY : S_LSCAN;
						end
					end
				end
				S_COPY: begin
					if (addr_q == load_q && !v_s1) begin
						nr_q    <= load_q;
						i_q     <= '0;
						total_q <= '0;
						k_q     <= '0;
						state_q <= S_FRD;
					end
				end
				S_LSCAN: begin
					if (lead_better) begin
						found_q <= 1'b1;
					end
					if (addr_q == load_q && !v_s1) begin
						if (found_q) begin
							state_q <= S_AREA;
						end else begin
							i_q     <= '0;
							total_q <= '0;
							k_q     <= '0;
							state_q <= S_FRD;
						end
					end
				end
				S_AREA: begin
					state_q <= S_TLA;
				end
				S_TLA: begin
					addr_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_GATHER;
				end
				S_GATHER: begin
					if (take) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (gather_done) begin
						dsel_q  <= '0;
						state_q <= S_DSEL;
					end
				end
				S_DSEL: begin
					state_q <= (use_mean || use_wmean) ? S_DWAIT : S_WRES;
				end
				S_DWAIT: begin
					if (ddone) begin
						if (dsel_q == 2'd3) begin
							state_q <= S_WRES;
						end else begin
							dsel_q  <= dsel_q + 1'b1;
							state_q <= S_DSEL;
						end
					end
				end
				S_WRES: begin
					nr_q    <= nr_q + 1'b1;
					addr_q  <= '0;
					found_q <= 1'b0;
					state_q <= S_LSCAN;
				end
				S_FRD: begin
					if (!filt_q) begin
						total_q <= nr_q;
						i_q     <= '0;
						state_q <= S_ERD;
					end else if (i_q == nr_q) begin
						if (total_q == '0) begin
							ovalid_q <= 1'b1;
							i_q      <= nr_q - 1'b1;
							state_q  <= S_EWAIT;
						end else begin
							i_q     <= '0;
							state_q <= S_ERD;
						end
					end else begin
						state_q <= S_FLAT;
					end
				end
				S_FLAT: begin
					addr_q  <= '0;
					drop_q  <= 1'b0;
					state_q <= S_FSCAN;
				end
				S_FSCAN: begin
					if (contained) begin
						drop_q <= 1'b1;
					end
					if (addr_q == nr_q && !v_s1) begin
						total_q <= total_q + CNT_W'(!drop_q);
						i_q     <= i_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_ERD: begin
					if (i_q == nr_q) begin
						load_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_ELAT;
					end
				end
				S_ELAT: begin
					if (!res_rdata[0]) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ERD;
					end else begin
						ovalid_q <= 1'b1;
						k_q      <= k_q + 1'b1;
						state_q  <= S_EWAIT;
					end
				end
				S_EWAIT: begin
					if (res.ready) begin
						ovalid_q <= 1'b0;
						i_q      <= i_q + 1'b1;
						state_q  <= S_ERD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		gi_s2  <= gi;
		box_s2 <= d_box;
		s_s2   <= d_s;
		tk_s2  <= det_rdata[0];
		idx_s2 <= idx_s1;
		ia_s3  <= AREA_W'(gi_s2[2*CW-1:CW]) * AREA_W'(gi_s2[CW-1:0]);
		box_s3 <= box_s2;
		s_s3   <= s_s2;
		tk_s3  <= tk_s2;
		idx_s3 <= idx_s2;
		for (int k = 0; k < 4; k++) begin
			wp_s3[k] <= WP_W'(s_s2) * WP_W'(box_s2[(3-k)*CW +: CW]);
		end

		case (state_q)
			S_LSCAN: begin
				if (lead_better) begin
					lead_box_q <= d_box;
					lead_s_q   <= d_s;
				end
			end
			S_AREA: begin
				la_q <= AREA_W'(lead_box_q[2*CW-1:CW]) * AREA_W'(lead_box_q[CW-1:0]);
			end
			S_TLA: begin
				tla_q     <= TLA_W'(thr_q) * TLA_W'(la_q);
				la_zero_q <= (la_q == '0);
				ws_q      <= '0;
				for (int k = 0; k < 4; k++) begin
					sum_q[k]  <= '0;
					wsum_q[k] <= '0;
				end
			end
			S_GATHER: begin
				if (take) begin
					ws_q <= ws_q + WS_W'(s_s3);
					for (int k = 0; k < 4; k++) begin
						sum_q[k]  <= sum_q[k] + SUM_W'(box_s3[(3-k)*CW +: CW]);
						wsum_q[k] <= wsum_q[k] + WSUM_W'(wp_s3[k]);
					end
				end
			end
			S_DSEL: begin
				if (!(use_mean || use_wmean)) begin
					for (int k = 0; k < 4; k++) begin
						rc_q[k] <= lead_box_q[(3-k)*CW +: CW];
					end
				end
			end
			S_DWAIT: begin
				if (ddone) begin
					rc_q[dsel_q] <= dquo[CW-1:0];
				end
			end
			S_FRD: begin
				if (filt_q && i_q == nr_q && total_q == '0) begin
					{ox_q, oy_q, ow_q, oh_q} <= '0;
					os_q    <= '0;
					olast_q <= 1'b1;
					onos_q  <= 1'b1;
					oovf_q  <= ovf_q;
				end
			end
			S_FLAT: begin
				ri_q  <= r_box;
				ris_q <= res_rdata[SW:1];
			end
			S_ELAT: begin
				if (res_rdata[0]) begin
					{ox_q, oy_q, ow_q, oh_q, os_q} <= res_rdata[ENT_W-1:1];
					olast_q <= ((k_q + 1'b1) == total_q);
					onos_q  <= 1'b0;
					oovf_q  <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid        = ovalid_q;
	assign res.out_x        = ox_q;
	assign res.out_y        = oy_q;
	assign res.out_w        = ow_q;
	assign res.out_h        = oh_q;
	assign res.out_score    = os_q;
	assign res.out_last     = olast_q;
	assign res.no_survivors = onos_q;
	assign res.overflowed   = oovf_q;

`ifndef SYNTH
	a_valid_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == S_EWAIT))
		else $error("result valid outside emit");
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_q <= CNT_W'(N))
		else $error("load count beyond capacity");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> (state_q == S_LOAD))
		else $error("config write while a set is in flight");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dstart |-> !dbusy)
		else $error("divider started while busy");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.no_survivors) |-> res.out_last)
		else $error("empty result not marked last");
`endif
endmodule
`default_nettype wire

// ----- dv/tb_cluster_nms_box_merge.sv -----
// Self-checking testbench for the cluster NMS box merge block.
`timescale 1ns / 1ps
module tb_cluster_nms_box_merge;
	import cnbm_pkg::*;

	localparam logic [MODE_W-1:0] MODE_LEADER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ODD    = 2'd3;
	localparam int NDET = DEF_MAX_DETECTIONS;

	typedef struct packed {
		logic [11:0] x, y, w, h;
		logic [15:0] s;
		logic        last;
	} det_t;

	typedef struct packed {
		logic [11:0] x, y, w, h;
		logic [15:0] s;
		logic        last, none, ovf;
	} mbox_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cnbm_det_if det_if ();
	cnbm_res_if res_if ();

	cluster_nms_box_merge dut (
		.clk(clk), .arst_n(arst_n), .det(det_if), .res(res_if),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	det_t  det_pending_q[$];
	mbox_t merged_exp_q[$];
	int    errors = 0;
	bit    no_gaps = 0;

	// block state as predicted
	det_t             det_store[NDET];
	int               n_loaded = 0;
	bit               ovf_seen = 0;
	logic [THR_W-1:0] thr_m = THR_RESET;
	logic [1:0]       mode_m = MODE_MEAN;
	logic             filt_m = 1'b1;

	function automatic longint unsigned umax(longint unsigned a, longint unsigned b);
		return a > b ? a : b;
	endfunction
	function automatic longint unsigned umin(longint unsigned a, longint unsigned b);
		return a < b ? a : b;
	endfunction

	function automatic void isect(det_t a, det_t b, output longint unsigned ix,
			output longint unsigned iy, output longint unsigned iw, output longint unsigned ih);
		longint unsigned x1, y1, x2, y2;
		x1 = umax(a.x, b.x);
		y1 = umax(a.y, b.y);
		x2 = umin(64'(a.x) + a.w, 64'(b.x) + b.w);
		y2 = umin(64'(a.y) + a.h, 64'(b.y) + b.h);
		ix = 0; iy = 0; iw = 0; ih = 0;
		if (x2 > x1 && y2 > y1) begin
			ix = x1; iy = y1; iw = x2 - x1; ih = y2 - y1;
		end
	endfunction

	function automatic bit leader_takes(det_t ld, det_t c);
		longint unsigned la, ix, iy, iw, ih;
		la = 64'(ld.w) * ld.h;
		if (la == 0) return 1'b1;
		isect(ld, c, ix, iy, iw, ih);
		return iw * ih * 64'd65536 > 64'(thr_m) * la;
	endfunction

	function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	task automatic predict_merge(det_t d);
		det_t merged[NDET];
		bit taken[NDET];
		bit keep[NDET];
		int nr, total, k, lead, cnt;
		bit found;
		longint unsigned sx, sy, sw, sh, wx, wy, ww, wh, ws, ix, iy, iw, ih;
		det_t ld, r, c;
		mbox_t o;
		if (n_loaded < NDET) begin
			det_store[n_loaded] = d;
			n_loaded++;
		end else
			ovf_seen = 1;
		if (!d.last) return;
		nr = 0;
		if (thr_m >= THR_ONE) begin
			for (int i = 0; i < n_loaded; i++) merged[i] = det_store[i];
			nr = n_loaded;
		end else begin
			for (int i = 0; i < NDET; i++) taken[i] = 0;
			forever begin
				found = 0; lead = 0;
				for (int i = 0; i < n_loaded; i++)
					if (!taken[i] && (!found || det_store[i].s >= det_store[lead].s)) begin
						lead = i; found = 1;
					end
				if (!found) break;
				ld = det_store[lead];
				cnt = 0; sx = 0; sy = 0; sw = 0; sh = 0;
				wx = 0; wy = 0; ww = 0; wh = 0; ws = 0;
				for (int i = 0; i < n_loaded; i++) begin
					c = det_store[i];
					if (taken[i] || !leader_takes(ld, c)) continue;
					taken[i] = 1;
					cnt++;
					sx += c.x; sy += c.y; sw += c.w; sh += c.h;
					ws += c.s;
					wx += 64'(c.s) * c.x; wy += 64'(c.s) * c.y;
					ww += 64'(c.s) * c.w; wh += 64'(c.s) * c.h;
				end
				taken[lead] = 1;
				r = ld;
				if (mode_m == MODE_MEAN && cnt > 0) begin
					r.x = 12'(round_div(sx, cnt)); r.y = 12'(round_div(sy, cnt));
					r.w = 12'(round_div(sw, cnt)); r.h = 12'(round_div(sh, cnt));
				end else if (mode_m == MODE_WMEAN && ws > 0) begin
					r.x = 12'(round_div(wx, ws)); r.y = 12'(round_div(wy, ws));
					r.w = 12'(round_div(ww, ws)); r.h = 12'(round_div(wh, ws));
				end
				merged[nr++] = r;
			end
		end
		total = 0;
		for (int i = 0; i < nr; i++) begin
			keep[i] = 1;
			if (filt_m)
				for (int j = 0; j < nr; j++) begin
					if (j == i) continue;
					isect(merged[i], merged[j], ix, iy, iw, ih);
					if (ix == merged[i].x && iy == merged[i].y &&
							iw == merged[i].w && ih == merged[i].h) begin
						keep[i] = 0;
						break;
					end
				end
			if (keep[i]) total++;
		end
		if (total == 0) begin
			o = '0;
			o.last = 1; o.none = 1; o.ovf = ovf_seen;
			merged_exp_q = {merged_exp_q, o};
		end else begin
			k = 0;
			for (int i = 0; i < nr; i++) begin
				if (!keep[i]) continue;
				o.x = merged[i].x; o.y = merged[i].y; o.w = merged[i].w; o.h = merged[i].h;
				o.s = merged[i].s;
				o.last = (k + 1 == total);
				o.none = 0;
				o.ovf = ovf_seen;
				merged_exp_q = {merged_exp_q, o};
				k++;
			end
		end
		n_loaded = 0;
		ovf_seen = 0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// detection driver
	int det_gap;
	det_t det_cur;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_if.valid <= 1'b0;
			det_gap <= 0;
		end else begin
			if (det_if.valid && det_if.ready)
				predict_merge(det_cur);
			if (!det_if.valid || det_if.ready) begin
				if (det_gap > 0) begin
					det_gap <= det_gap - 1;
					det_if.valid <= 1'b0;
				end else if (det_pending_q.size() > 0) begin
					det_cur = det_pending_q.pop_front();
					det_if.box_x <= det_cur.x;
					det_if.box_y <= det_cur.y;
					det_if.box_w <= det_cur.w;
					det_if.box_h <= det_cur.h;
					det_if.score <= det_cur.s;
					det_if.last <= det_cur.last;
					det_if.valid <= 1'b1;
					det_gap <= no_gaps ? 0 : $urandom_range(0, 6);
				end else
					det_if.valid <= 1'b0;
			end
		end
	end

	// result monitor
	int res_stall;
	mbox_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			res_stall <= 0;
		end else if (res_if.valid && res_if.ready) begin
			if (merged_exp_q.size() == 0)
				report_mismatch("unexpected transfer, x", res_if.out_x, -1);
			else begin
				want = merged_exp_q.pop_front();
				if (res_if.out_x !== want.x) report_mismatch("out_x", res_if.out_x, want.x);
				if (res_if.out_y !== want.y) report_mismatch("out_y", res_if.out_y, want.y);
				if (res_if.out_w !== want.w) report_mismatch("out_w", res_if.out_w, want.w);
				if (res_if.out_h !== want.h) report_mismatch("out_h", res_if.out_h, want.h);
				if (res_if.out_score !== want.s)
					report_mismatch("out_score", res_if.out_score, want.s);
				if (res_if.out_last !== want.last)
					report_mismatch("out_last", res_if.out_last, want.last);
				if (res_if.no_survivors !== want.none)
					report_mismatch("no_survivors", res_if.no_survivors, want.none);
				if (res_if.overflowed !== want.ovf)
					report_mismatch("overflowed", res_if.overflowed, want.ovf);
			end
			res_stall <= no_gaps ? 0 : $urandom_range(0, 6);
			res_if.ready <= no_gaps;
		end else if (res_stall > 0) begin
			res_stall <= res_stall - 1;
			res_if.ready <= (res_stall == 1);
		end else
			res_if.ready <= 1'b1;
	end

	task automatic add_det(int x, int y, int w, int h, int s, bit last);
		det_t d;
		d.x = 12'(x); d.y = 12'(y); d.w = 12'(w); d.h = 12'(h); d.s = 16'(s);
		d.last = last;
		det_pending_q = {det_pending_q, d};
	endtask

	task automatic add_random_set(int n);
		int cx, cy, bw, bh, sbase;
		cx = $urandom_range(0, 4095);
		cy = $urandom_range(0, 4095);
		bw = $urandom_range(0, 300);
		bh = $urandom_range(0, 300);
		sbase = $urandom_range(0, 65535);
		for (int i = 0; i < n; i++)
			case ($urandom_range(0, 5))
				0: add_det($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 65535), i == n - 1);
				1: add_det(cx, cy, bw, bh, sbase, i == n - 1);
				default: add_det((cx + $urandom_range(0, 40)) % 4096,
					(cy + $urandom_range(0, 40)) % 4096,
					bw + $urandom_range(0, 40), bh + $urandom_range(0, 40),
					$urandom_range(0, 1) ? $urandom_range(0, 65535)
						: (sbase + $urandom_range(0, 3)) % 65536, i == n - 1);
			endcase
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
			REG_THR:  thr_m = v;
			REG_MODE: mode_m = v[1:0];
			REG_FILT: filt_m = v[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		while (det_pending_q.size() != 0 || det_if.valid || merged_exp_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	int thr_tab[8]  = '{32768, 65536, 0, 65535, 1, 16384, 52000, 40000};
	logic [MODE_W-1:0] mode_tab[8] = '{MODE_MEAN, MODE_WMEAN, MODE_WMEAN, MODE_LEADER,
		MODE_ODD, MODE_MEAN, MODE_WMEAN, MODE_MEAN};
	int filt_tab[8] = '{1, 1, 0, 1, 0, 1, 1, 0};
	int phase_items;

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_THR;
		cfg_wdata = '0;
		det_if.valid = 1'b0;
		det_if.box_x = '0; det_if.box_y = '0; det_if.box_w = '0; det_if.box_h = '0;
		det_if.score = '0; det_if.last = 1'b0;
		res_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 8; p++) begin
			cfg_write(REG_THR, p == 7 ? CFG_DATA_W'($urandom_range(0, 65536))
				: CFG_DATA_W'(thr_tab[p]));
			cfg_write(REG_MODE, p == 7 ? CFG_DATA_W'($urandom_range(0, 3))
				: CFG_DATA_W'(mode_tab[p]));
			cfg_write(REG_FILT, CFG_DATA_W'(filt_tab[p]));
			no_gaps = (p == 2 || p == 5);
			case (p)
				0: begin
					// zero-area leader takes all
					add_det(100, 100, 0, 0, 16'hFFFF, 0);
					add_det(100, 100, 50, 50, 16'h0100, 0);
					add_det(4095, 4095, 4095, 4095, 0, 1);
					// score tie, contained box
					add_det(10, 10, 20, 20, 16'h8000, 0);
					add_det(12, 12, 20, 20, 16'h8000, 0);
					add_det(500, 500, 10, 10, 16'h7FFF, 0);
					add_det(502, 500, 4, 4, 1, 1);
					add_det(0, 0, 4095, 4095, 16'hFFFF, 1);
				end
				1: begin
					// identical boxes drop each other
					add_det(7, 7, 30, 30, 5, 0);
					add_det(7, 7, 30, 30, 9, 1);
				end
				2: begin
					// zero weight sum
					add_det(1, 1, 10, 10, 0, 0);
					add_det(3, 3, 10, 10, 0, 1);
				end
				3: add_random_set(66);
				5: add_random_set(64);
				default: ;
			endcase
			phase_items = 0;
			while (phase_items < 4) begin
				int n;
				n = $urandom_range(1, 8);
				add_random_set(n);
				phase_items += n;
			end
			wait_idle();
		end
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#40ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
